[src/hlsrgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HLS to RGB888 package
// Shared pixel types, pipeline control type and fixed-point constants of the
// HLS (0..240 scale) to RGB888 converter.
// ----------------------------------------------------------------------------
package hlsrgb_pkg;

	// Number of register stages from input to output.
	localparam int NUM_STAGES = 5;

	// Input pixel on the 0..240 scale.
	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] lightness;
		logic [7:0] saturation;
	} pix_t;

	// Output pixel, 8 bits per channel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Per-stage load enables; stage k register takes new contents when set.
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} stage_ctrl_t;

	// Contents of the first pipeline stage.
	typedef struct packed {
		logic [7:0]  hue_r;      // wrapped ramp argument for red
		logic [7:0]  hue_g;      // wrapped ramp argument for green
		logic [7:0]  hue_b;      // wrapped ramp argument for blue
		logic [16:0] m2;         // upper magic level, units of 1/57600
		logic [7:0]  lightness;
		logic [11:0] grey_num;   // (L*255 + 120) >> 4
		logic        grey;       // saturation is zero
	} front_t;

	// Hue segment bounds of the piecewise-linear ramp.
	localparam logic [7:0] HUE_SEG1 = 8'd40;
	localparam logic [7:0] HUE_SEG2 = 8'd120;
	localparam logic [7:0] HUE_SEG3 = 8'd160;
	localparam logic [7:0] HUE_MAX  = 8'd240;
	localparam logic [7:0] HUE_THIRD = 8'd80;

	// Half-step offset added on the rising and falling ramp, units of 1/2304000.
	localparam logic signed [24:0] RAMP_OFS = 25'sd4800;

	// Channel scaling: ceil((17*x + 76800) / 153600), evaluated on n - 1.
	localparam logic signed [30:0] CHAN_OFS_M1 = 31'sd76799;
	localparam logic [29:0]        CHAN_SAT_M1 = 30'd39167999;

	// Reciprocals for division by 15 (grey path) and by 75 (channel path).
	localparam logic [12:0] RECIP_15 = 13'd4370;
	localparam logic [14:0] RECIP_75 = 15'd27963;

	localparam logic [7:0] CHAN_MAX = 8'd255;

endpackage
`default_nettype wire

[src/hls_to_rgb888_converter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HLS to RGB888 converter
// Converts one pixel from hue, lightness and saturation on a 0..240 scale to
// 8-bit red, green and blue in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The pix channel (pix_valid, pix_ready, pix) takes one pixel per transfer;
//   the rgb channel (rgb_valid, rgb_ready, rgb) gives one result per transfer,
//   in the order the pixels came in.
//   A pixel taken on pix passes through stages 1 to 5 in order and is shown
//   on rgb from the output stage register.
//   The pipeline takes one pixel per cycle while the output does not stall;
//   each of the five stages can then take a new pixel in every cycle.
//   When rgb_ready is low, the output stage holds its result and the stages
//   ahead of it keep filling; pix_ready falls only once all five stages hold
//   a pixel. Empty stages are filled even during a stall.
//   Reset clears all stage valid bits, so the pipeline comes up empty with
//   pix_ready high and rgb_valid low. Data registers are not reset.
//   Zero saturation gives a grey level on all three channels; otherwise each
//   channel follows the hue ramp and is clamped to 0..255 and rounded up.
// ----------------------------------------------------------------------------
module hls_to_rgb888_converter_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	output logic                  pix_ready,
	input  wire hlsrgb_pkg::pix_t pix,
	output logic                  rgb_valid,
	input  wire logic             rgb_ready,
	output hlsrgb_pkg::rgb_t      rgb
);
	import hlsrgb_pkg::*;

	stage_ctrl_t ctrl;
	front_t      front_s1;
	logic [7:0]  level_s4;
	logic        grey_s4;
	logic [7:0]  red_s5;
	logic [7:0]  green_s5;
	logic [7:0]  blue_s5;

	// Valid bits and per-stage load enables for the whole pipeline.
	hlsrgb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.ctrl      (ctrl)
	);

	// Stage 1: magic level, grey numerator and wrapped hue arguments.
	hlsrgb_front u_front (
		.clk      (clk),
		.load     (ctrl.load[0]),
		.pix      (pix),
		.front_s1 (front_s1)
	);

	// Stages 2 to 4: grey level, shared by all three lanes.
	hlsrgb_grey u_grey (
		.clk         (clk),
		.ctrl        (ctrl),
		.grey_num_s1 (front_s1.grey_num),
		.grey_s1     (front_s1.grey),
		.level_s4    (level_s4),
		.grey_s4     (grey_s4)
	);

	// Stages 2 to 5: one lane per channel, red at hue+80, blue at hue-80.
	hlsrgb_lane u_lane_red (
		.clk          (clk),
		.ctrl         (ctrl),
		.hue_s1       (front_s1.hue_r),
		.m2_s1        (front_s1.m2),
		.lightness_s1 (front_s1.lightness),
		.level_s4     (level_s4),
		.grey_s4      (grey_s4),
		.chan_s5      (red_s5)
	);

	hlsrgb_lane u_lane_green (
		.clk          (clk),
		.ctrl         (ctrl),
		.hue_s1       (front_s1.hue_g),
		.m2_s1        (front_s1.m2),
		.lightness_s1 (front_s1.lightness),
		.level_s4     (level_s4),
		.grey_s4      (grey_s4),
		.chan_s5      (green_s5)
	);

	hlsrgb_lane u_lane_blue (
		.clk          (clk),
		.ctrl         (ctrl),
		.hue_s1       (front_s1.hue_b),
		.m2_s1        (front_s1.m2),
		.lightness_s1 (front_s1.lightness),
		.level_s4     (level_s4),
		.grey_s4      (grey_s4),
		.chan_s5      (blue_s5)
	);

	// The lane output registers form the output stage.
	assign rgb.red   = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue  = blue_s5;

endmodule
`default_nettype wire

[src/hlsrgb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HLS to RGB888 pipeline control
// Tracks one valid bit per stage and derives per-stage load enables: bubbles
// collapse; an output stall holds each occupied stage with no gap after it.
// ----------------------------------------------------------------------------
module hlsrgb_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output hlsrgb_pkg::stage_ctrl_t       ctrl
);
	import hlsrgb_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES:0]   rdy;

	// A stage can take new contents when it is empty or its successor moves.
	always_comb begin
		rdy[NUM_STAGES] = out_ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	assign ctrl.load = rdy[NUM_STAGES-1:0];
	assign in_ready  = rdy[0];
	assign out_valid = valid_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[NUM_STAGES-1] && !out_ready |=> valid_q[NUM_STAGES-1])
		else $error("output stage lost its item during a stall");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&valid_q))
		else $error("input blocked while a stage is empty");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[NUM_STAGES-2] && rdy[NUM_STAGES-1] |=> valid_q[NUM_STAGES-1])
		else $error("item did not reach the output stage");

endmodule
`default_nettype wire

[src/hlsrgb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HLS to RGB888 front stage
// Forms the upper magic level, the grey numerator and the three wrapped hue
// arguments, and registers them as stage 1.
// ----------------------------------------------------------------------------
module hlsrgb_front (
	input  wire logic                clk,
	input  wire logic                load,
	input  wire hlsrgb_pkg::pix_t    pix,
	output hlsrgb_pkg::front_t       front_s1
);
	import hlsrgb_pkg::*;

	logic [15:0] ls;
	logic [15:0] l240;
	logic [15:0] s240;
	logic [17:0] m2_hi;
	logic [16:0] m2;
	logic [15:0] grey_full;
	logic [8:0]  hue_r_raw;
	front_t      nxt;

	always_comb begin
		ls   = pix.lightness * pix.saturation;
		l240 = {pix.lightness, 8'b0} - {4'b0, pix.lightness, 4'b0};
		s240 = {pix.saturation, 8'b0} - {4'b0, pix.saturation, 4'b0};

		// Above half lightness the level is L + S - L*S; the sum stays positive.
		m2_hi = 18'(l240) + 18'(s240) - 18'(ls) - 18'd120;
		if (pix.lightness <= 8'd120) begin
			m2 = 17'(ls) + 17'(l240) + 17'd120;
		end else begin
			m2 = m2_hi[16:0];
		end

		// L*255 + 120 never exceeds 16 bits.
		grey_full = {pix.lightness, 8'b0} - 16'(pix.lightness) + 16'd120;

		hue_r_raw = {1'b0, pix.hue} + {1'b0, HUE_THIRD};
		nxt.hue_r = (hue_r_raw > {1'b0, HUE_MAX}) ? 8'(hue_r_raw - {1'b0, HUE_MAX})
			: hue_r_raw[7:0];
		nxt.hue_g = (pix.hue > HUE_MAX) ? pix.hue - HUE_MAX : pix.hue;
		nxt.hue_b = (pix.hue < HUE_THIRD) ? pix.hue + (HUE_MAX - HUE_THIRD)
			: pix.hue - HUE_THIRD;

		nxt.m2        = m2;
		nxt.lightness = pix.lightness;
		nxt.grey_num  = grey_full[15:4];
		nxt.grey      = (pix.saturation == 8'd0);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			front_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

[src/hlsrgb_grey.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HLS to RGB888 grey path
// Divides the grey numerator by 15 with a reciprocal multiply, clamps it to
// 255 and carries it with the grey flag through stages 2 to 4.
// ----------------------------------------------------------------------------
module hlsrgb_grey (
	input  wire logic                    clk,
	input  wire hlsrgb_pkg::stage_ctrl_t ctrl,
	input  wire logic [11:0]             grey_num_s1,
	input  wire logic                    grey_s1,
	output logic [7:0]                   level_s4,
	output logic                         grey_s4
);
	import hlsrgb_pkg::*;

	logic [24:0] quot_prod;
	logic [8:0]  quot_s2;
	logic        grey_s2;
	logic [8:0]  quot_s3;
	logic        grey_s3;

	assign quot_prod = grey_num_s1 * RECIP_15;

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			quot_s2 <= quot_prod[24:16];
			grey_s2 <= grey_s1;
		end
		if (ctrl.load[2]) begin
			quot_s3 <= quot_s2;
			grey_s3 <= grey_s2;
		end
		if (ctrl.load[3]) begin
			level_s4 <= quot_s3[8] ? CHAN_MAX : quot_s3[7:0];
			grey_s4  <= grey_s3;
		end
	end

endmodule
`default_nettype wire

[src/hlsrgb_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HLS to RGB888 channel lane
// Evaluates the hue ramp for one channel, scales it to 0..255 with an exact
// ceiling and clamp, and selects the grey level when saturation is zero.
// ----------------------------------------------------------------------------
module hlsrgb_lane (
	input  wire logic                    clk,
	input  wire hlsrgb_pkg::stage_ctrl_t ctrl,
	input  wire logic [7:0]              hue_s1,
	input  wire logic [16:0]             m2_s1,
	input  wire logic [7:0]              lightness_s1,
	input  wire logic [7:0]              level_s4,
	input  wire logic                    grey_s4,
	output logic [7:0]                   chan_s5
);
	import hlsrgb_pkg::*;

	// Stage 2: lower level, slope and segment factor.
	logic [16:0]        l480;
	logic signed [18:0] m1;
	logic signed [18:0] diff;
	logic signed [24:0] base;
	logic [5:0]         fac;
	logic               ramp;

	logic signed [18:0] diff_s2;
	logic signed [24:0] base_s2;
	logic [5:0]         fac_s2;

	always_comb begin
		l480 = {lightness_s1, 9'b0} - {4'b0, lightness_s1, 5'b0};
		m1   = $signed({2'b0, l480}) - $signed({2'b0, m2_s1});
		diff = $signed({1'b0, m2_s1, 1'b0}) - $signed({2'b0, l480});
		if (hue_s1 < HUE_SEG1) begin
			fac  = hue_s1[5:0];
			ramp = 1'b1;
		end else if (hue_s1 < HUE_SEG2) begin
			fac  = HUE_SEG1[5:0];
			ramp = 1'b0;
		end else if (hue_s1 < HUE_SEG3) begin
			fac  = 6'(HUE_SEG3 - hue_s1);
			ramp = 1'b1;
		end else begin
			fac  = 6'd0;
			ramp = 1'b0;
		end
		// 40*m1 as 32*m1 + 8*m1.
		base = (25'(m1) <<< 5) + (25'(m1) <<< 3) + (ramp ? RAMP_OFS : 25'sd0);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			diff_s2 <= diff;
			base_s2 <= base;
			fac_s2  <= fac;
		end
	end

	// Stage 3: ramp value in units of 1/2304000.
	logic signed [6:0]  fac_sx;
	logic signed [25:0] slope;
	logic signed [24:0] slope_t;
	logic signed [24:0] ramp_s3;

	always_comb begin
		fac_sx  = $signed({1'b0, fac_s2});
		slope   = diff_s2 * fac_sx;
		slope_t = $signed(slope[24:0]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			ramp_s3 <= base_s2 + slope_t;
		end
	end

	// Stage 4: scaled numerator minus one, its clamp flags and its quotient by 2048.
	logic signed [30:0] num_m1;
	logic               neg_s4;
	logic               sat_s4;
	logic [14:0]        quo_s4;

	assign num_m1 = (31'(ramp_s3) <<< 4) + 31'(ramp_s3) + CHAN_OFS_M1;

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			neg_s4 <= num_m1[30];
			sat_s4 <= !num_m1[30] && (num_m1[29:0] >= CHAN_SAT_M1);
			quo_s4 <= num_m1[25:11];
		end
	end

	// Stage 5: divide by 75, add one for the ceiling, clamp and pick grey.
	logic [29:0] div_prod;
	logic [7:0]  ceil_val;
	logic [7:0]  chan;

	always_comb begin
		div_prod = quo_s4 * RECIP_75;
		ceil_val = div_prod[28:21] + 8'd1;
		if (grey_s4) begin
			chan = level_s4;
		end else if (neg_s4) begin
			chan = 8'd0;
		end else if (sat_s4) begin
			chan = CHAN_MAX;
		end else begin
			chan = ceil_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			chan_s5 <= chan;
		end
	end

endmodule
`default_nettype wire
